### hdl/ngsim_pkg.sv
// Shared types, constants and saturating helpers for the n-body gravity simulator.
// Used by ngsim_alu and nbody_gravity_euler_sim; depends on nothing.
`default_nettype none

package ngsim_pkg;

    localparam int WORD_W             = 64;
    localparam int MASS_W             = 41;
    localparam int FRAC_BITS          = 32;
    localparam int DEFAULT_MAX_BODIES = 64;
    localparam int CFG_DATA_W         = 40;
    localparam int CFG_INDEX_W        = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAV_CONST  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DIST_SQ = 2'd3;

    localparam logic [15:0] RST_STEP_COUNT  = 16'd1000;
    localparam logic [31:0] RST_TIME_STEP   = 32'd42949673;
    localparam logic [39:0] RST_GRAV_CONST  = 40'd17179869184;
    localparam logic [31:0] RST_MIN_DIST_SQ = 32'd42950;

    // shared unit operations
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } alu_req_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    function automatic word_t sat_add(word_t a, word_t b);
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        return s[WORD_W-1:0];
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        return s[WORD_W-1:0];
    endfunction

    // signed result from sign and magnitude, big flags a magnitude past 64 bits
    function automatic word_t from_mag(logic neg, logic big, logic [WORD_W-1:0] m);
        if (neg)
            return (big || m[WORD_W-1]) ? WORD_MIN : word_t'({WORD_W{1'b0}} - m);
        return (big || m[WORD_W-1]) ? WORD_MAX : word_t'(m);
    endfunction

endpackage

`default_nettype wire

### hdl/ngsim_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependency.
`default_nettype none

module ngsim_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/ngsim_alu.sv
// Shared multi-cycle arithmetic unit: fixed-point multiply (4 partial products),
// divide (one quotient bit per cycle) and square root (one root bit per cycle).
// Depends on ngsim_pkg.
`default_nettype none

module ngsim_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  ngsim_pkg::alu_req_t req,
    input  ngsim_pkg::word_t    a,
    input  ngsim_pkg::word_t    b,
    output ngsim_pkg::word_t    result,
    output logic                done
);
    import ngsim_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_FIN  = 2'd2;

    logic [1:0]   phase_reg, phase_next;
    logic [1:0]   op_reg, op_next;
    logic         neg_reg, neg_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [63:0]  x_reg, x_next;     // mul: |a|, div: divisor
    logic [63:0]  y_reg, y_next;     // mul: |b|, div: quotient, sqrt: root
    logic [127:0] w_reg, w_next;     // mul: product, div: dividend bits, sqrt: radicand
    logic [66:0]  r_reg, r_next;     // div/sqrt partial remainder
    word_t        result_reg, result_next;
    logic         done_reg, done_next;

    logic [63:0]  mag_a, mag_b, div_hi;
    logic [31:0]  xs, ys;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [64:0]  rem65, diff65;
    logic [66:0]  rem_s, trial;
    logic [63:0]  pm;
    logic [64:0]  pm_inc;
    logic         p_big, p_frac, p_inc, last_iter;

    assign mag_a  = a[63] ? (64'd0 - a) : a;
    assign mag_b  = b[63] ? (64'd0 - b) : b;
    assign div_hi = mag_a >> (WORD_W - FRAC_BITS);

    assign xs = cnt_reg[0] ? x_reg[63:32] : x_reg[31:0];
    assign ys = cnt_reg[1] ? y_reg[63:32] : y_reg[31:0];
    assign pp = xs * ys;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    assign rem65  = {r_reg[63:0], w_reg[63]};
    assign diff65 = rem65 - {1'b0, x_reg};
    assign rem_s  = {r_reg[64:0], w_reg[127:126]};
    assign trial  = {1'b0, y_reg, 2'b01};

    assign pm     = w_reg[FRAC_BITS+63:FRAC_BITS];
    assign p_big  = |w_reg[127:FRAC_BITS+64];
    assign p_frac = |w_reg[FRAC_BITS-1:0];
    assign p_inc  = neg_reg & p_frac;
    assign pm_inc = {1'b0, pm} + {64'd0, p_inc};

    assign last_iter = (op_reg == OP_MUL) ? (cnt_reg == 6'd3) : (cnt_reg == 6'd63);

    always_comb
    begin
        phase_next  = phase_reg;
        op_next     = op_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        w_next      = w_reg;
        r_next      = r_reg;
        result_next = result_reg;
        done_next   = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    neg_next = a[63] ^ b[63];
                    cnt_next = '0;
                    case (req.op)
                        OP_MUL:
                        begin
                            x_next     = mag_a;
                            y_next     = mag_b;
                            w_next     = '0;
                            phase_next = PH_RUN;
                        end
                        OP_DIV:
                        begin
                            if (mag_a == 64'd0)
                            begin
                                result_next = '0;
                                done_next   = 1'b1;
                            end
                            else if (mag_b == 64'd0 || div_hi >= mag_b)
                            begin
                                result_next = from_mag(a[63] ^ b[63], 1'b1, 64'd0);
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                x_next     = mag_b;
                                y_next     = '0;
                                w_next     = {64'd0, mag_a << FRAC_BITS};
                                r_next     = {3'd0, div_hi};
                                phase_next = PH_RUN;
                            end
                        end
                        OP_SQRT:
                        begin
                            y_next     = '0;
                            w_next     = {64'd0, a} << FRAC_BITS;
                            r_next     = '0;
                            phase_next = PH_RUN;
                        end
                        default:
                        begin
                            result_next = '0;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            PH_RUN:
            begin
                case (op_reg)
                    OP_MUL:
                    begin
                        w_next = w_reg + pp_sh;
                    end
                    OP_DIV:
                    begin
                        w_next = {w_reg[126:0], 1'b0};
                        if (rem65 >= {1'b0, x_reg})
                        begin
                            r_next = {3'd0, diff65[63:0]};
                            y_next = {y_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            r_next = {3'd0, rem65[63:0]};
                            y_next = {y_reg[62:0], 1'b0};
                        end
                    end
                    default:
                    begin
                        w_next = {w_reg[125:0], 2'b00};
                        if (rem_s >= trial)
                        begin
                            r_next = rem_s - trial;
                            y_next = {y_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            r_next = rem_s;
                            y_next = {y_reg[62:0], 1'b0};
                        end
                    end
                endcase
                if (last_iter)
                    phase_next = PH_FIN;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            PH_FIN:
            begin
                case (op_reg)
                    OP_MUL:  result_next = from_mag(neg_reg, p_big | pm_inc[64], pm_inc[63:0]);
                    OP_DIV:  result_next = from_mag(neg_reg, 1'b0, y_reg);
                    default: result_next = word_t'(y_reg);
                endcase
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        w_reg      <= w_next;
        r_reg      <= r_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

### hdl/nbody_gravity_euler_sim.sv
// Top level of the all-pairs n-body gravity simulator with Euler integration.
// Depends on ngsim_pkg, ngsim_ram (body stores) and ngsim_alu (shared mul/div/sqrt).
//
//   port group   | dir | handshake            | contents
//   -------------+-----+----------------------+------------------------------------
//   input body   | in  | in_valid / in_stall  | pos_*, vel_*, body_mass, load_last
//   result body  | out | out_valid / out_stall| out_pos_*, out_vel_*, out_last
//   config write | in  | cfg_we               | cfg_index, cfg_data
//
// Loading a body writes one store slot per axis. The item with load_last starts a run
// whose length is set by the single shared unit, whose divide and root take longer than
// the multiply (a divide with a zero numerator or an overflowing quotient finishes
// without iterating). Each body is then read out and waits in the output register; the
// next body is read out only once the output register has emptied.
// No item is accepted during a load, a run or the read-out. Reset clears the sequencer, the body
// count and the output valid and loads the register defaults; stores need no clearing.
// A stalled output transfer holds only the read-out; the run itself never stalls.
`default_nettype none

module nbody_gravity_euler_sim #(
    parameter int MAX_BODIES = ngsim_pkg::DEFAULT_MAX_BODIES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [ngsim_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ngsim_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input bodies
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  ngsim_pkg::word_t                     pos_x,
    input  ngsim_pkg::word_t                     pos_y,
    input  ngsim_pkg::word_t                     pos_z,
    input  ngsim_pkg::word_t                     vel_x,
    input  ngsim_pkg::word_t                     vel_y,
    input  ngsim_pkg::word_t                     vel_z,
    input  logic [ngsim_pkg::MASS_W-1:0]         body_mass,
    input  logic                                 load_last,
    // result bodies
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output ngsim_pkg::word_t                     out_pos_x,
    output ngsim_pkg::word_t                     out_pos_y,
    output ngsim_pkg::word_t                     out_pos_z,
    output ngsim_pkg::word_t                     out_vel_x,
    output ngsim_pkg::word_t                     out_vel_y,
    output ngsim_pkg::word_t                     out_vel_z,
    output logic                                 out_last
);
    import ngsim_pkg::*;

    localparam int IW    = $clog2(MAX_BODIES);
    localparam int CW    = $clog2(MAX_BODIES + 1);
    localparam int AW    = IW + 2;
    localparam int DEPTH = MAX_BODIES * 4;   // row per body, one slot per axis

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_LOAD   = 5'd1;
    localparam logic [4:0] S_STEP   = 5'd2;
    localparam logic [4:0] S_WAIT   = 5'd3;
    localparam logic [4:0] S_P_RDI  = 5'd4;
    localparam logic [4:0] S_P_RDJ  = 5'd5;
    localparam logic [4:0] S_P_DIF  = 5'd6;
    localparam logic [4:0] S_P_SQ   = 5'd7;
    localparam logic [4:0] S_P_FLR  = 5'd8;
    localparam logic [4:0] S_P_G    = 5'd9;
    localparam logic [4:0] S_P_MRD  = 5'd10;
    localparam logic [4:0] S_P_AI   = 5'd11;
    localparam logic [4:0] S_P_MRI  = 5'd12;
    localparam logic [4:0] S_P_AJ   = 5'd13;
    localparam logic [4:0] S_P_SAJ  = 5'd14;
    localparam logic [4:0] S_P_UD   = 5'd15;
    localparam logic [4:0] S_P_TJ   = 5'd16;
    localparam logic [4:0] S_P_RAJ  = 5'd17;
    localparam logic [4:0] S_P_WAJ  = 5'd18;
    localparam logic [4:0] S_P_RAI  = 5'd19;
    localparam logic [4:0] S_P_WAI  = 5'd20;
    localparam logic [4:0] S_E_RA   = 5'd21;
    localparam logic [4:0] S_E_M1   = 5'd22;
    localparam logic [4:0] S_E_V    = 5'd23;
    localparam logic [4:0] S_E_P    = 5'd24;
    localparam logic [4:0] S_O_WAIT = 5'd25;
    localparam logic [4:0] S_O_RD   = 5'd26;
    localparam logic [4:0] S_O_CAP  = 5'd27;

    // control registers
    logic [4:0]  state_reg, state_next;
    logic [4:0]  ret_reg, ret_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [1:0]  k_reg, k_next;
    logic [15:0] step_reg, step_next;
    logic        ovalid_reg, ovalid_next;
    logic [15:0] step_count_reg;
    logic [31:0] time_step_reg;
    logic [39:0] grav_reg;
    logic [31:0] min_dsq_reg;

    // datapath registers
    word_t       dsq_reg, dsq_next;
    word_t       dist_reg, dist_next;
    word_t       g_reg, g_next;
    word_t       ai_reg, ai_next;
    word_t       aj_reg, aj_next;
    word_t       ud_reg, ud_next;
    word_t       tmp_reg, tmp_next;
    word_t       d_reg [3];
    word_t       d_next [3];
    word_t       ipos_reg [3];
    word_t       ivel_reg [3];
    logic [MASS_W-1:0] imass_reg;
    logic        ilast_reg;
    word_t       opos_reg [3];
    word_t       opos_next [3];
    word_t       ovel_reg [3];
    word_t       ovel_next [3];
    logic        olast_reg, olast_next;

    // stores
    logic        pos_we, vel_we, acc_we, mass_we;
    logic [AW-1:0] pos_waddr, vel_waddr, acc_waddr;
    logic [AW-1:0] pos_raddr, acc_raddr, vel_raddr;
    logic [IW-1:0] mass_waddr, mass_raddr;
    word_t       pos_wdata, vel_wdata, acc_wdata;
    word_t       pos_rdata, vel_rdata, acc_rdata;
    logic [MASS_W-1:0] mass_rdata;

    // shared unit
    alu_req_t    alu_req;
    word_t       alu_a, alu_b, alu_result;
    logic        alu_done;

    // helpers
    logic        in_xfer, out_xfer;
    word_t       diff_w, floor_w, dsq_fl, vnew_w, ts_w;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = ovalid_reg && !out_stall;

    assign ts_w    = {32'd0, time_step_reg};
    assign floor_w = (min_dsq_reg == 32'd0) ? word_t'(1) : {32'd0, min_dsq_reg};
    assign dsq_fl  = (dsq_reg < floor_w) ? floor_w : dsq_reg;
    assign diff_w  = sat_sub(tmp_reg, pos_rdata);
    assign vnew_w  = sat_add(vel_rdata, alu_result);

    ngsim_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_pos_ram (
        .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .raddr(pos_raddr), .rdata(pos_rdata)
    );

    ngsim_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_vel_ram (
        .clk(clk), .we(vel_we), .waddr(vel_waddr), .wdata(vel_wdata),
        .raddr(vel_raddr), .rdata(vel_rdata)
    );

    ngsim_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_acc_ram (
        .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
        .raddr(acc_raddr), .rdata(acc_rdata)
    );

    ngsim_ram #(.WIDTH(MASS_W), .DEPTH(MAX_BODIES)) u_mass_ram (
        .clk(clk), .we(mass_we), .waddr(mass_waddr), .wdata(imass_reg),
        .raddr(mass_raddr), .rdata(mass_rdata)
    );

    ngsim_alu u_alu (
        .clk(clk), .rst_n(rst_n), .req(alu_req), .a(alu_a), .b(alu_b),
        .result(alu_result), .done(alu_done)
    );

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        cnt_next    = cnt_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        step_next   = step_reg;
        ovalid_next = out_xfer ? 1'b0 : ovalid_reg;
        olast_next  = olast_reg;
        dsq_next    = dsq_reg;
        dist_next   = dist_reg;
        g_next      = g_reg;
        ai_next     = ai_reg;
        aj_next     = aj_reg;
        ud_next     = ud_reg;
        tmp_next    = tmp_reg;
        for (int n = 0; n < 3; n++)
        begin
            d_next[n]    = d_reg[n];
            opos_next[n] = opos_reg[n];
            ovel_next[n] = ovel_reg[n];
        end

        // default store access: body i, axis k
        pos_we     = 1'b0;
        vel_we     = 1'b0;
        acc_we     = 1'b0;
        mass_we    = 1'b0;
        pos_waddr  = {i_reg, k_reg};
        vel_waddr  = {i_reg, k_reg};
        acc_waddr  = {i_reg, k_reg};
        mass_waddr = cnt_reg[IW-1:0];
        pos_wdata  = ipos_reg[k_reg];
        vel_wdata  = ivel_reg[k_reg];
        acc_wdata  = '0;
        pos_raddr  = {i_reg, k_reg};
        vel_raddr  = {i_reg, k_reg};
        acc_raddr  = {i_reg, k_reg};
        mass_raddr = i_reg;

        alu_req.start = 1'b0;
        alu_req.op    = OP_MUL;
        alu_a         = '0;
        alu_b         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    k_next = '0;
                    if (cnt_reg < CW'(MAX_BODIES))
                        state_next = S_LOAD;
                    else if (load_last)
                    begin
                        step_next  = '0;
                        state_next = S_STEP;
                    end
                end
            end
            S_LOAD:
            begin
                pos_we    = 1'b1;
                vel_we    = 1'b1;
                acc_we    = 1'b1;
                mass_we   = (k_reg == 2'd0);
                pos_waddr = {cnt_reg[IW-1:0], k_reg};
                vel_waddr = {cnt_reg[IW-1:0], k_reg};
                acc_waddr = {cnt_reg[IW-1:0], k_reg};
                if (k_reg == 2'd2)
                begin
                    cnt_next = cnt_reg + CW'(1);
                    if (ilast_reg)
                    begin
                        step_next  = '0;
                        state_next = S_STEP;
                    end
                    else
                        state_next = S_IDLE;
                end
                else
                    k_next = k_reg + 2'd1;
            end
            S_STEP:
            begin
                i_next = '0;
                k_next = '0;
                if (step_reg == step_count_reg)
                    state_next = S_O_WAIT;
                else
                begin
                    step_next = step_reg + 16'd1;
                    if (cnt_reg >= CW'(2))
                    begin
                        j_next     = IW'(1);
                        dsq_next   = '0;
                        state_next = S_P_RDI;
                    end
                    else
                        state_next = S_E_RA;
                end
            end
            S_WAIT:
            begin
                if (alu_done)
                    state_next = ret_reg;
            end

            // pair distance
            S_P_RDI:
            begin
                state_next = S_P_RDJ;
            end
            S_P_RDJ:
            begin
                pos_raddr  = {j_reg, k_reg};
                tmp_next   = pos_rdata;
                state_next = S_P_DIF;
            end
            S_P_DIF:
            begin
                d_next[k_reg] = diff_w;
                alu_req.start = 1'b1;
                alu_req.op    = OP_MUL;
                alu_a         = diff_w;
                alu_b         = diff_w;
                ret_next      = S_P_SQ;
                state_next    = S_WAIT;
            end
            S_P_SQ:
            begin
                dsq_next = sat_add(dsq_reg, alu_result);
                if (k_reg == 2'd2)
                begin
                    k_next     = '0;
                    state_next = S_P_FLR;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_P_RDI;
                end
            end
            S_P_FLR:
            begin
                dsq_next      = dsq_fl;
                alu_req.start = 1'b1;
                alu_req.op    = OP_SQRT;
                alu_a         = dsq_fl;
                ret_next      = S_P_G;
                state_next    = S_WAIT;
            end
            S_P_G:
            begin
                dist_next     = alu_result;
                alu_req.start = 1'b1;
                alu_req.op    = OP_DIV;
                alu_a         = {24'd0, grav_reg};
                alu_b         = dsq_reg;
                ret_next      = S_P_MRD;
                state_next    = S_WAIT;
            end

            // mass-scaled pair strength
            S_P_MRD:
            begin
                g_next     = alu_result;
                mass_raddr = j_reg;
                state_next = S_P_AI;
            end
            S_P_AI:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = OP_MUL;
                alu_a         = g_reg;
                alu_b         = {{(WORD_W-MASS_W){1'b0}}, mass_rdata};
                ret_next      = S_P_MRI;
                state_next    = S_WAIT;
            end
            S_P_MRI:
            begin
                ai_next    = alu_result;
                state_next = S_P_AJ;
            end
            S_P_AJ:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = OP_MUL;
                alu_a         = g_reg;
                alu_b         = {{(WORD_W-MASS_W){1'b0}}, mass_rdata};
                ret_next      = S_P_SAJ;
                state_next    = S_WAIT;
            end
            S_P_SAJ:
            begin
                aj_next    = alu_result;
                state_next = S_P_UD;
            end

            // per axis: unit vector, then j gains and i loses
            S_P_UD:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = OP_DIV;
                alu_a         = d_reg[k_reg];
                alu_b         = dist_reg;
                ret_next      = S_P_TJ;
                state_next    = S_WAIT;
            end
            S_P_TJ:
            begin
                ud_next       = alu_result;
                alu_req.start = 1'b1;
                alu_req.op    = OP_MUL;
                alu_a         = aj_reg;
                alu_b         = alu_result;
                ret_next      = S_P_RAJ;
                state_next    = S_WAIT;
            end
            S_P_RAJ:
            begin
                acc_raddr  = {j_reg, k_reg};
                state_next = S_P_WAJ;
            end
            S_P_WAJ:
            begin
                acc_we        = 1'b1;
                acc_waddr     = {j_reg, k_reg};
                acc_wdata     = sat_add(acc_rdata, alu_result);
                alu_req.start = 1'b1;
                alu_req.op    = OP_MUL;
                alu_a         = ai_reg;
                alu_b         = ud_reg;
                ret_next      = S_P_RAI;
                state_next    = S_WAIT;
            end
            S_P_RAI:
            begin
                state_next = S_P_WAI;
            end
            S_P_WAI:
            begin
                acc_we    = 1'b1;
                acc_wdata = sat_sub(acc_rdata, alu_result);
                if (k_reg == 2'd2)
                begin
                    k_next   = '0;
                    dsq_next = '0;
                    if (CW'(j_reg) + CW'(1) < cnt_reg)
                    begin
                        j_next     = j_reg + IW'(1);
                        state_next = S_P_RDI;
                    end
                    else if (CW'(i_reg) + CW'(2) < cnt_reg)
                    begin
                        i_next     = i_reg + IW'(1);
                        j_next     = i_reg + IW'(2);
                        state_next = S_P_RDI;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = S_E_RA;
                    end
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_P_UD;
                end
            end

            // Euler update: velocity, then position with the new velocity
            S_E_RA:
            begin
                state_next = S_E_M1;
            end
            S_E_M1:
            begin
                acc_we        = 1'b1;
                acc_wdata     = '0;
                alu_req.start = 1'b1;
                alu_req.op    = OP_MUL;
                alu_a         = acc_rdata;
                alu_b         = ts_w;
                ret_next      = S_E_V;
                state_next    = S_WAIT;
            end
            S_E_V:
            begin
                vel_we        = 1'b1;
                vel_wdata     = vnew_w;
                alu_req.start = 1'b1;
                alu_req.op    = OP_MUL;
                alu_a         = vnew_w;
                alu_b         = ts_w;
                ret_next      = S_E_P;
                state_next    = S_WAIT;
            end
            S_E_P:
            begin
                pos_we    = 1'b1;
                pos_wdata = sat_add(pos_rdata, alu_result);
                if (k_reg == 2'd2)
                begin
                    k_next = '0;
                    if (CW'(i_reg) + CW'(1) < cnt_reg)
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = S_E_RA;
                    end
                    else
                        state_next = S_STEP;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_E_RA;
                end
            end

            // read-out, one body per output transfer
            S_O_WAIT:
            begin
                k_next = '0;
                if (!ovalid_reg)
                    state_next = S_O_RD;
            end
            S_O_RD:
            begin
                state_next = S_O_CAP;
            end
            S_O_CAP:
            begin
                opos_next[k_reg] = pos_rdata;
                ovel_next[k_reg] = vel_rdata;
                if (k_reg == 2'd2)
                begin
                    ovalid_next = 1'b1;
                    olast_next  = (CW'(i_reg) + CW'(1) == cnt_reg);
                    if (CW'(i_reg) + CW'(1) == cnt_reg)
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = S_O_WAIT;
                    end
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_O_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            cnt_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            step_reg       <= '0;
            ovalid_reg     <= 1'b0;
            step_count_reg <= RST_STEP_COUNT;
            time_step_reg  <= RST_TIME_STEP;
            grav_reg       <= RST_GRAV_CONST;
            min_dsq_reg    <= RST_MIN_DIST_SQ;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            cnt_reg    <= cnt_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP_COUNT:  step_count_reg <= cfg_data[15:0];
                    REG_TIME_STEP:   time_step_reg  <= cfg_data[31:0];
                    REG_GRAV_CONST:  grav_reg       <= cfg_data[39:0];
                    REG_MIN_DIST_SQ: min_dsq_reg    <= cfg_data[31:0];
                    default:         min_dsq_reg    <= min_dsq_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dsq_reg   <= dsq_next;
        dist_reg  <= dist_next;
        g_reg     <= g_next;
        ai_reg    <= ai_next;
        aj_reg    <= aj_next;
        ud_reg    <= ud_next;
        tmp_reg   <= tmp_next;
        olast_reg <= olast_next;
        for (int n = 0; n < 3; n++)
        begin
            d_reg[n]    <= d_next[n];
            opos_reg[n] <= opos_next[n];
            ovel_reg[n] <= ovel_next[n];
        end
        if (in_xfer)
        begin
            ipos_reg[0] <= pos_x;
            ipos_reg[1] <= pos_y;
            ipos_reg[2] <= pos_z;
            ivel_reg[0] <= vel_x;
            ivel_reg[1] <= vel_y;
            ivel_reg[2] <= vel_z;
            imass_reg   <= body_mass;
            ilast_reg   <= load_last;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_pos_x = opos_reg[0];
    assign out_pos_y = opos_reg[1];
    assign out_pos_z = opos_reg[2];
    assign out_vel_x = ovel_reg[0];
    assign out_vel_y = ovel_reg[1];
    assign out_vel_z = ovel_reg[2];
    assign out_last  = olast_reg;

    // shared unit finishes only while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> state_reg == S_WAIT)
        else $error("shared unit finished outside wait state");

    // every request is followed by a wait for its result
    a_start_waits: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |=> state_reg == S_WAIT)
        else $error("shared unit started without waiting");

    // body count stays within the stores
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_BODIES))
        else $error("body count beyond store depth");

endmodule

`default_nettype wire
